[rtl/smma_pkg.sv]
// Shared types and constants for the scaled matrix multiply-add block.
// Holds field widths, command/status/register codes and the FSM state type.
// No dependencies.
package smma_pkg;

   // Fixed field widths of the stream and register interfaces
   localparam int ELEM_W    = 16;  // Q8.8 element, alpha, beta
   localparam int IDX_W     = 4;   // row / column index
   localparam int SIZE_W    = 5;   // size registers
   localparam int CMD_W     = 2;
   localparam int STAT_W    = 2;
   localparam int RES_W     = 32;  // Q16.16 result
   localparam int CSR_IDX_W = 3;

   // Defaults for the top-level parameters
   localparam int MAX_DIM_DEF   = 16;
   localparam int FRAC_BITS_DEF = 8;

   // Register reset values
   localparam logic signed [ELEM_W-1:0] GAIN_RST = 16'sd256;
   localparam logic [SIZE_W-1:0]        SIZE_RST = 5'd16;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD_A  = 2'd0,
      CMD_LOAD_B  = 2'd1,
      CMD_COMPUTE = 2'd2
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_LOAD_OK = 2'd0,
      STAT_RESULT  = 2'd1,
      STAT_ERROR   = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ALPHA = 3'd0,
      CSR_BETA  = 3'd1,
      CSR_ROWS  = 3'd2,
      CSR_COLS  = 3'd3,
      CSR_INNER = 3'd4
   } csr_reg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_FIN
   } state_type;

endpackage

[rtl/scaled_matrix_multiply_add_top.sv]
// Scaled matrix multiply-add: X = alpha*A*B + beta*C over element stores.
// Depends on smma_pkg (widths, codes, state type).
//
// req_ channel: one beat per item. tuser = command (load A, load B, compute),
//   tdata = row, column and Q8.8 element value.
// rsp_ channel: exactly one beat per request. tuser = status, tdata = row,
//   column and Q16.16 saturated result (zero unless status is a result).
// csr_ channel: register writes (alpha, beta, rows, cols, inner size);
//   always ready, write only while no request is in flight.
// Sequence: a load or a rejected request goes through the finish state into
//   the output register. A compute runs the inner terms one after another
//   (nk = effective inner size; run is skipped when nk is zero), paced by the
//   single read port of each store, then drains the multiply / accumulate
//   pipeline until it is empty and finishes.
// Requests: one at a time; the next is accepted in the cycle after the
//   response is loaded. A new request is taken while a finished response
//   still waits.
// Reset: control state and registers return to defaults; store contents are
//   undefined until loaded. A stalled receiver holds the response in the
//   output register; the next one waits in the finish state, and input stalls.
module scaled_matrix_multiply_add_top #(
   parameter int MAX_DIM   = smma_pkg::MAX_DIM_DEF,
   parameter int FRAC_BITS = smma_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // request stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [23:0]                        req_tdata,  // row_index, col_index, elem_value
   input  logic [smma_pkg::CMD_W-1:0]         req_tuser,  // command
   // response stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [39:0]                        rsp_tdata,  // out_row, out_col, result_value
   output logic [smma_pkg::STAT_W-1:0]        rsp_tuser,  // status
   // register write channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [smma_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [smma_pkg::ELEM_W-1:0]        csr_data
);

   localparam int ELEM_W  = smma_pkg::ELEM_W;
   localparam int IDX_W   = smma_pkg::IDX_W;
   localparam int SIZE_W  = smma_pkg::SIZE_W;
   localparam int RES_W   = smma_pkg::RES_W;
   localparam int DEPTH   = MAX_DIM * MAX_DIM;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int WIDE_W  = ADDR_W + SIZE_W + 1;
   localparam int P1_W    = 2 * ELEM_W;
   localparam int P2_W    = 3 * ELEM_W;
   localparam int ACC_W   = P2_W + SIZE_W + 1;

   localparam logic signed [ACC_W-1:0] SAT_HI = {{(ACC_W-RES_W+1){1'b0}}, {(RES_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] SAT_LO = {{(ACC_W-RES_W+1){1'b1}}, {(RES_W-1){1'b0}}};

   // ---------------------------------------------------------------------
   // Configuration registers
   logic signed [ELEM_W-1:0] alpha_ff, beta_ff;
   logic [SIZE_W-1:0]        rows_ff, cols_ff, inner_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= smma_pkg::GAIN_RST;
         beta_ff  <= smma_pkg::GAIN_RST;
         rows_ff  <= smma_pkg::SIZE_RST;
         cols_ff  <= smma_pkg::SIZE_RST;
         inner_ff <= smma_pkg::SIZE_RST;
      end else if (csr_valid) begin
         case (csr_index)
            smma_pkg::CSR_ALPHA: alpha_ff <= $signed(csr_data);
            smma_pkg::CSR_BETA:  beta_ff  <= $signed(csr_data);
            smma_pkg::CSR_ROWS:  rows_ff  <= csr_data[SIZE_W-1:0];
            smma_pkg::CSR_COLS:  cols_ff  <= csr_data[SIZE_W-1:0];
            smma_pkg::CSR_INNER: inner_ff <= csr_data[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective sizes, clamped to the store dimension
   logic [SIZE_W-1:0] nr, nc, nk;
   assign nr = (32'(rows_ff)  > MAX_DIM) ? SIZE_W'(MAX_DIM) : rows_ff;
   assign nc = (32'(cols_ff)  > MAX_DIM) ? SIZE_W'(MAX_DIM) : cols_ff;
   assign nk = (32'(inner_ff) > MAX_DIM) ? SIZE_W'(MAX_DIM) : inner_ff;

   // ---------------------------------------------------------------------
   // Request decode
   logic [IDX_W-1:0]         row_in, col_in;
   logic signed [ELEM_W-1:0] elem_in;
   logic                     req_acc;
   logic                     a_we, b_we, cmp_go;
   smma_pkg::status_type     stat_dec;

   assign row_in  = req_tdata[IDX_W-1:0];
   assign col_in  = req_tdata[2*IDX_W-1:IDX_W];
   assign elem_in = $signed(req_tdata[2*IDX_W+ELEM_W-1:2*IDX_W]);
   assign req_acc = req_tvalid && req_tready;

   always_comb begin
      a_we     = 1'b0;
      b_we     = 1'b0;
      cmp_go   = 1'b0;
      stat_dec = smma_pkg::STAT_ERROR;
      case (smma_pkg::cmd_type'(req_tuser))
         smma_pkg::CMD_LOAD_A: begin
            if (SIZE_W'(row_in) < nr && SIZE_W'(col_in) < nk) begin
               a_we     = req_acc;
               stat_dec = smma_pkg::STAT_LOAD_OK;
            end
         end
         smma_pkg::CMD_LOAD_B: begin
            if (SIZE_W'(row_in) < nk && SIZE_W'(col_in) < nc) begin
               b_we     = req_acc;
               stat_dec = smma_pkg::STAT_LOAD_OK;
            end
         end
         smma_pkg::CMD_COMPUTE: begin
            if (SIZE_W'(row_in) < nr && SIZE_W'(col_in) < nc) begin
               cmp_go   = req_acc;
               stat_dec = smma_pkg::STAT_RESULT;
            end
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------------
   // Control FSM
   smma_pkg::state_type state_ff, state_in;
   logic [SIZE_W-1:0]   k_ff, k_in;
   logic [2:0]          pipe_vld_ff, pipe_vld_in;
   logic                issue, fin_take, out_free;

   assign out_free = !rsp_tvalid || rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         smma_pkg::ST_IDLE: begin
            if (req_acc) begin
               if (cmp_go)
                  state_in = (nk == '0) ? smma_pkg::ST_DRAIN : smma_pkg::ST_RUN;
               else
                  state_in = smma_pkg::ST_FIN;
            end
         end
         smma_pkg::ST_RUN: begin
            if (k_ff == nk - 1'b1)
               state_in = smma_pkg::ST_DRAIN;
         end
         smma_pkg::ST_DRAIN: begin
            if (pipe_vld_ff == '0)
               state_in = smma_pkg::ST_FIN;
         end
         smma_pkg::ST_FIN: begin
            if (out_free)
               state_in = smma_pkg::ST_IDLE;
         end
         default: state_in = smma_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      issue      = 1'b0;
      fin_take   = 1'b0;
      case (state_ff)
         smma_pkg::ST_IDLE:  req_tready = 1'b1;
         smma_pkg::ST_RUN:   issue      = 1'b1;
         smma_pkg::ST_DRAIN: ;
         smma_pkg::ST_FIN:   fin_take   = out_free;
         default: ;
      endcase
   end

   assign k_in        = issue ? k_ff + 1'b1 : '0;
   assign pipe_vld_in = {pipe_vld_ff[1:0], issue};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= smma_pkg::ST_IDLE;
         k_ff        <= '0;
         pipe_vld_ff <= '0;
      end else begin
         state_ff    <= state_in;
         k_ff        <= k_in;
         pipe_vld_ff <= pipe_vld_in;
      end
   end

   // Item context held for the whole compute
   logic [IDX_W-1:0]     row_ff, col_ff;
   smma_pkg::status_type stat_ff;

   always_ff @(posedge clock) begin
      if (req_acc) begin
         row_ff  <= row_in;
         col_ff  <= col_in;
         stat_ff <= stat_dec;
      end
   end

   // ---------------------------------------------------------------------
   // Element stores: one write port (loads), one registered read port each
   logic [WIDE_W-1:0] wr_addr_w, a_rd_w, b_rd_w;
   logic [ADDR_W-1:0] wr_addr, a_rd_addr, b_rd_addr;

   assign wr_addr_w = WIDE_W'(row_in) * WIDE_W'(MAX_DIM) + WIDE_W'(col_in);
   assign a_rd_w    = WIDE_W'(row_ff) * WIDE_W'(MAX_DIM) + WIDE_W'(k_ff);
   assign b_rd_w    = WIDE_W'(k_ff) * WIDE_W'(MAX_DIM) + WIDE_W'(col_ff);
   assign wr_addr   = wr_addr_w[ADDR_W-1:0];
   assign a_rd_addr = a_rd_w[ADDR_W-1:0];
   assign b_rd_addr = b_rd_w[ADDR_W-1:0];

   logic signed [ELEM_W-1:0] a_mem [0:DEPTH-1];
   logic signed [ELEM_W-1:0] b_mem [0:DEPTH-1];
   logic signed [ELEM_W-1:0] a_rd_ff, b_rd_ff;

   always_ff @(posedge clock) begin
      if (a_we)
         a_mem[wr_addr] <= elem_in;
      a_rd_ff <= a_mem[a_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (b_we)
         b_mem[wr_addr] <= elem_in;
      b_rd_ff <= b_mem[b_rd_addr];
   end

   // ---------------------------------------------------------------------
   // MAC pipeline: alpha*a, then *b, then accumulate
   logic signed [P1_W-1:0]   prod1_ff, prod1_in;
   logic signed [ELEM_W-1:0] bd_ff;
   logic signed [P2_W-1:0]   prod2_ff, prod2_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [P1_W-1:0]   beta_prod;

   assign prod1_in  = alpha_ff * a_rd_ff;
   assign prod2_in  = prod1_ff * bd_ff;
   assign beta_prod = beta_ff * elem_in;

   always_ff @(posedge clock) begin
      if (pipe_vld_ff[0]) begin
         prod1_ff <= prod1_in;
         bd_ff    <= b_rd_ff;
      end
      if (pipe_vld_ff[1])
         prod2_ff <= prod2_in;
   end

   // Accumulator starts at beta*C aligned to the product scale
   always_comb begin
      acc_in = acc_ff;
      if (req_acc)
         acc_in = ACC_W'(beta_prod) <<< FRAC_BITS;
      else if (pipe_vld_ff[2])
         acc_in = acc_ff + ACC_W'(prod2_ff);
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // ---------------------------------------------------------------------
   // Floor shift to Q16.16, saturate, output register
   logic signed [ACC_W-1:0] acc_sh;
   logic signed [RES_W-1:0] sat_val;

   assign acc_sh = acc_ff >>> FRAC_BITS;

   always_comb begin
      if (acc_sh > SAT_HI)
         sat_val = SAT_HI[RES_W-1:0];
      else if (acc_sh < SAT_LO)
         sat_val = SAT_LO[RES_W-1:0];
      else
         sat_val = acc_sh[RES_W-1:0];
   end

   logic                 rsp_valid_ff, rsp_valid_in;
   smma_pkg::status_type rsp_stat_ff;
   logic [IDX_W-1:0]     rsp_row_ff, rsp_col_ff;
   logic [RES_W-1:0]     rsp_val_ff;

   assign rsp_valid_in = fin_take ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else
         rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (fin_take) begin
         rsp_stat_ff <= stat_ff;
         rsp_row_ff  <= row_ff;
         rsp_col_ff  <= col_ff;
         rsp_val_ff  <= (stat_ff == smma_pkg::STAT_RESULT) ? sat_val : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_val_ff, rsp_col_ff, rsp_row_ff};
   assign rsp_tuser  = rsp_stat_ff;

`ifndef SYNTH
   // An accepted request always leaves the idle state
   assert property (@(posedge clock) disable iff (reset)
      req_acc |=> state_ff != smma_pkg::ST_IDLE)
      else $error("request accepted but FSM stayed idle");

   // No MAC beat may be in flight once the FSM is back to idle
   assert property (@(posedge clock) disable iff (reset)
      state_ff == smma_pkg::ST_IDLE |-> pipe_vld_ff == '0)
      else $error("MAC pipeline busy while idle");

   // Inner counter stays below the effective inner size while issuing
   assert property (@(posedge clock) disable iff (reset)
      state_ff == smma_pkg::ST_RUN |-> k_ff < nk)
      else $error("inner counter out of range");

   // A response is loaded only when the output slot is free
   assert property (@(posedge clock) disable iff (reset)
      fin_take |-> (!rsp_valid_ff || rsp_tready))
      else $error("response overwrote a pending beat");
`endif

endmodule
